>>> rtl/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 decoder: code unit constants and the
// record that carries the units released by one byte.
// No dependencies.
package u8u16_pkg;

  // Most units that one input byte can release
  localparam int unsigned MaxUnits = 4;
  localparam int unsigned CountW   = $clog2(MaxUnits + 1);

  localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

  // Units released by one byte, unit 0 goes out first
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] units;
    logic [CountW-1:0]         count;
  } u8u16_run_t;

endpackage

>>> rtl/u8u16_if.sv
// Handshake channels of the UTF-8 to UTF-16 decoder: the byte channel and
// the code unit channel, each with valid, ready and payload.
// No dependencies.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_last;
  logic        text_last;

  modport source (output valid, output code_unit, output run_last, output text_last,
                  input ready);
  modport sink (input valid, input code_unit, input run_last, input text_last,
                output ready);
endinterface

>>> rtl/u8u16_dec.sv
// Sequence state and unit generation for one UTF-8 byte.
// Depends on u8u16_pkg.
module u8u16_dec (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [7:0]            text_byte,
  input  logic                  text_end,
  output u8u16_pkg::u8u16_run_t run
);

  logic        pend_r, pend_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic [11:0] held_r, held_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;

  logic        is_cont;
  logic        is_lead;
  logic        tail_ascii;
  logic [1:0]  need;
  logic        complete;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic [2:0]  n_flush;
  logic [2:0]  n_tail;
  logic [2:0]  n_units;

  // Classify the byte and the open sequence
  always_comb begin
    is_cont    = (text_byte[7:6] == 2'b10);
    is_lead    = (text_byte[7:5] == 3'b110) || (text_byte[7:4] == 4'b1110) ||
                 (text_byte[7:3] == 5'b11110);
    tail_ascii = !text_byte[7];
    if (lead_r[7:5] == 3'b110) begin
      need = 2'd1;
    end else if (lead_r[7:4] == 4'b1110) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end
    complete = ({1'b0, hcnt_r} + 3'd1) >= {1'b0, need};
    case (need)
      2'd1:    cp = {10'd0, lead_r[4:0], 6'd0} | {3'd0, held_r, text_byte[5:0]};
      2'd2:    cp = {5'd0, lead_r[3:0], 12'd0} | {3'd0, held_r, text_byte[5:0]};
      default: cp = {lead_r[2:0], held_r, text_byte[5:0]};
    endcase
    cp_off = cp - u8u16_pkg::SUPP_BASE;
  end

  // Build the unit list and the next sequence state
  always_comb begin
    pend_nxt  = pend_r;
    lead_nxt  = lead_r;
    held_nxt  = held_r;
    hcnt_nxt  = hcnt_r;
    n_flush   = 3'd0;
    n_tail    = 3'd0;
    n_units   = 3'd0;
    run.units = {u8u16_pkg::MaxUnits{u8u16_pkg::REPL_UNIT}};
    if (pend_r && is_cont && complete) begin
      // Sequence done: one unit, or a surrogate pair above the basic plane
      pend_nxt = 1'b0;
      lead_nxt = 8'd0;
      held_nxt = 12'd0;
      hcnt_nxt = 2'd0;
      if (cp[20:16] == 5'd0) begin
        n_units      = 3'd1;
        run.units[0] = cp[15:0];
      end else begin
        n_units      = 3'd2;
        run.units[0] = u8u16_pkg::HI_SURR_BASE + {5'd0, cp_off[20:10]};
        run.units[1] = u8u16_pkg::LO_SURR_BASE | {6'd0, cp_off[9:0]};
      end
    end else if (pend_r && is_cont) begin
      // Hold the payload; an early end replaces lead and payloads with 0xFFFD units
      if (text_end) begin
        n_units  = {1'b0, hcnt_r} + 3'd2;
        pend_nxt = 1'b0;
        lead_nxt = 8'd0;
        held_nxt = 12'd0;
        hcnt_nxt = 2'd0;
      end else begin
        held_nxt = {held_r[5:0], text_byte[5:0]};
        hcnt_nxt = hcnt_r + 2'd1;
      end
    end else begin
      // Flush any broken sequence, then take the byte as a new lead or release a unit for it
      if (pend_r) begin
        n_flush = {1'b0, hcnt_r} + 3'd1;
      end
      if (!is_lead || text_end) begin
        n_tail = 3'd1;
      end
      n_units = n_flush + n_tail;
      if (is_lead && !text_end) begin
        pend_nxt = 1'b1;
        lead_nxt = text_byte;
      end else begin
        pend_nxt = 1'b0;
        lead_nxt = 8'd0;
      end
      held_nxt = 12'd0;
      hcnt_nxt = 2'd0;
      for (int k = 0; k < u8u16_pkg::MaxUnits; k++) begin
        if (tail_ascii && (n_units == 3'(k + 1))) begin
          run.units[k] = {8'h00, text_byte};
        end
      end
    end
    run.count = n_units;
  end

  // Advance the sequence state on each byte taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      lead_r <= 8'd0;
      held_r <= 12'd0;
      hcnt_r <= 2'd0;
    end else if (load) begin
      pend_r <= pend_nxt;
      lead_r <= lead_nxt;
      held_r <= held_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

endmodule

>>> rtl/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 decoder: input register, decoder and
// unit buffer. Depends on u8u16_pkg, u8u16_in_if, u8u16_out_if, u8u16_dec.
//
// Takes one UTF-8 byte per item and releases zero to four UTF-16 code units,
// one per cycle while the unit channel is ready, with run_last on the final
// unit of each byte and text_last on the final unit of the text. A byte is
// held in an input register and then decoded into a four-entry unit buffer.
// Bytes flow at one per cycle while each releases at most one unit and the
// unit channel is ready; a byte that releases more units holds the input
// until the single-unit output port has drained the buffer to its last unit.
// Broken or truncated sequences give 0xFFFD per held byte.
module utf8_to_utf16_decoder (
  input logic         clk,
  input logic         rst_n,
  u8u16_in_if.sink    in_ch,
  u8u16_out_if.source out_ch
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  logic [u8u16_pkg::MaxUnits-1:0][15:0] units_r, units_nxt;
  logic [u8u16_pkg::CountW-1:0]         rem_r, rem_nxt;
  logic                                 end_r;

  u8u16_pkg::u8u16_run_t run;
  logic                  out_fire;
  logic                  buf_free;
  logic                  load;

  assign out_fire    = out_ch.valid && out_ch.ready;
  assign buf_free    = (rem_r == '0) ||
                       ((rem_r == u8u16_pkg::CountW'(1)) && out_ch.ready);
  assign load        = in_vld_r && buf_free;
  assign in_ch.ready = !in_vld_r || load;

  // Hold each accepted byte in the input register until the decoder takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.text_byte;
      in_end_r  <= in_ch.text_end;
    end
  end

  u8u16_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .text_byte (in_byte_r),
    .text_end  (in_end_r),
    .run       (run)
  );

  // Load the buffer with a new run, or shift out one unit
  always_comb begin
    units_nxt = units_r;
    rem_nxt   = rem_r;
    if (load) begin
      units_nxt = run.units;
      rem_nxt   = run.count;
    end else if (out_fire) begin
      units_nxt = {16'h0000, units_r[u8u16_pkg::MaxUnits-1:1]};
      rem_nxt   = rem_r - u8u16_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    units_r <= units_nxt;
    if (load) begin
      end_r <= in_end_r;
    end
  end

  // Drive the unit channel from the buffer head
  assign out_ch.valid     = (rem_r != '0);
  assign out_ch.code_unit = units_r[0];
  assign out_ch.run_last  = (rem_r == u8u16_pkg::CountW'(1));
  assign out_ch.text_last = (rem_r == u8u16_pkg::CountW'(1)) && end_r;

endmodule
